[sv/cnw_pkg.sv]
// Shared types, constants and strobe tables for the character LCD nibble writer.
// Used by every module of the block; no dependencies of its own.
package cnw_pkg;

   localparam int NUM_LINES     = 4;
   localparam int BUSY_WAIT_US  = 1000;
   localparam int E_PULSE_US    = 10;
   localparam int WAIT_MAX      = 32767;
   localparam int CLEAR_WAIT_US = 500;
   localparam int POWER_ON_US   = 25000;
   localparam int GAP_LONG_US   = 2000;
   localparam int GAP_SHORT_US  = 64;
   localparam int GAP_SETUP_US  = 2500;

   localparam int WAIT_W      = 15;
   localparam int WAIT_CALC_W = 18;
   localparam int STEP_W      = 4;
   localparam int ADDR_W      = 7;

   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd10;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

   localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;
   localparam logic [7:0] CMD_FUNCTION_SET  = 8'h28;
   localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
   localparam logic [7:0] CMD_RETURN_HOME   = 8'h02;
   localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
   localparam logic [7:0] CHAR_NEWLINE      = 8'd10;
   localparam logic [3:0] NIB_WAKE          = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT      = 4'h2;

   localparam logic [ADDR_W-1:0] LINE0_RESET = 7'd0;
   localparam logic [ADDR_W-1:0] LINE1_RESET = 7'd64;
   localparam logic [ADDR_W-1:0] LINE2_RESET = 7'd20;
   localparam logic [ADDR_W-1:0] LINE3_RESET = 7'd84;

   typedef enum logic [2:0] {
      REQ_INIT     = 3'd0,
      REQ_CHAR     = 3'd1,
      REQ_INSTR    = 3'd2,
      REQ_SET_LINE = 3'd3,
      REQ_GOTO     = 3'd4,
      REQ_CLEAR    = 3'd5,
      REQ_HOME     = 3'd6
   } req_code_type;

   // one queued command: either the whole init sequence or one byte write
   typedef struct packed {
      logic              is_init;
      logic              rs;
      logic [7:0]        data;
      logic [WAIT_W-1:0] wait0;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [3:0]        nibble;
      logic [WAIT_W-1:0] wait_us;
   } strobe_type;

   function automatic logic [WAIT_W-1:0] sat_wait(input logic [WAIT_CALC_W-1:0] w);
      logic [WAIT_W-1:0] r;
      if (w > WAIT_CALC_W'(WAIT_MAX)) r = WAIT_W'(WAIT_MAX);
      else r = w[WAIT_W-1:0];
      return r;
   endfunction

   function automatic strobe_type init_strobe(input logic [STEP_W-1:0] step);
      strobe_type s;
      logic [WAIT_W-1:0] w_pulse;
      logic [WAIT_W-1:0] w_long;
      logic [WAIT_W-1:0] w_setup;
      w_pulse = WAIT_W'(E_PULSE_US);
      w_long  = sat_wait(WAIT_CALC_W'(E_PULSE_US + GAP_LONG_US + BUSY_WAIT_US));
      w_setup = sat_wait(WAIT_CALC_W'(E_PULSE_US + GAP_SETUP_US + BUSY_WAIT_US));
      case (step)
         4'd0:  s = '{NIB_WAKE, sat_wait(WAIT_CALC_W'(POWER_ON_US))};
         4'd1:  s = '{NIB_WAKE, sat_wait(WAIT_CALC_W'(E_PULSE_US + GAP_LONG_US))};
         4'd2:  s = '{NIB_FOUR_BIT, sat_wait(WAIT_CALC_W'(E_PULSE_US + GAP_SHORT_US))};
         4'd3:  s = '{CMD_FUNCTION_SET[7:4], w_long};
         4'd4:  s = '{CMD_FUNCTION_SET[3:0], w_pulse};
         4'd5:  s = '{CMD_ENTRY_MODE[7:4], w_long};
         4'd6:  s = '{CMD_ENTRY_MODE[3:0], w_pulse};
         4'd7:  s = '{CMD_DISPLAY_ON[7:4], w_setup};
         4'd8:  s = '{CMD_DISPLAY_ON[3:0], w_pulse};
         4'd9:  s = '{CMD_RETURN_HOME[7:4], w_setup};
         4'd10: s = '{CMD_RETURN_HOME[3:0], w_pulse};
         default: s = '{4'h0, w_pulse};
      endcase
      return s;
   endfunction

endpackage

[sv/cnw_front.sv]
// Front end: accepts requests, holds line start registers and line/busy state,
// and turns each request into a queued command. Depends on cnw_pkg.
module cnw_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [2:0]                       req_type,
   input  logic [7:0]                       req_data_byte,
   input  logic [7:0]                       req_line_sel,
   input  logic [7:0]                       req_col,
   input  logic [7:0]                       req_row,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [cnw_pkg::ADDR_W-1:0]       csr_wdata,
   output logic                             q_push,
   output cnw_pkg::cmd_type                 q_cmd
);

   logic [cnw_pkg::ADDR_W-1:0] line_start_ff [4];
   logic [7:0] cur_line_ff, cur_line_in;
   logic       pend_ff, pend_in;

   logic       accept;
   logic       emit;
   logic       is_init;
   logic       rs;
   logic       use_col;
   logic       is_addr;
   logic [7:0] plain_byte;
   logic [7:0] target;
   logic [7:0] row_eff;
   logic [1:0] idx;
   logic [7:0] addr_byte;
   logic [cnw_pkg::WAIT_CALC_W-1:0] wait_calc;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff[0] <= cnw_pkg::LINE0_RESET;
         line_start_ff[1] <= cnw_pkg::LINE1_RESET;
         line_start_ff[2] <= cnw_pkg::LINE2_RESET;
         line_start_ff[3] <= cnw_pkg::LINE3_RESET;
         cur_line_ff      <= '0;
         pend_ff          <= 1'b0;
      end else begin
         if (csr_we) line_start_ff[csr_index] <= csr_wdata;
         if (accept) begin
            cur_line_ff <= cur_line_in;
            pend_ff     <= pend_in;
         end
      end
   end

   assign row_eff = (cnw_pkg::NUM_LINES == 1) ? 8'd0 : req_row;

   always_comb begin
      emit        = 1'b0;
      is_init     = 1'b0;
      rs          = 1'b0;
      use_col     = 1'b0;
      is_addr     = 1'b0;
      plain_byte  = req_data_byte;
      target      = 8'd0;
      idx         = 2'd0;
      cur_line_in = cur_line_ff;
      pend_in     = pend_ff;
      case (cnw_pkg::req_code_type'(req_type))
         cnw_pkg::REQ_INIT: begin
            emit        = 1'b1;
            is_init     = 1'b1;
            cur_line_in = 8'd0;
            pend_in     = 1'b0;
         end
         cnw_pkg::REQ_CHAR: begin
            emit = 1'b1;
            if (req_data_byte == cnw_pkg::CHAR_NEWLINE) begin
               is_addr = 1'b1;
               if (cur_line_ff >= 8'(cnw_pkg::NUM_LINES - 1)) target = 8'd0;
               else target = 8'(cur_line_ff + 8'd1);
            end else begin
               rs = 1'b1;
            end
         end
         cnw_pkg::REQ_INSTR: emit = 1'b1;
         cnw_pkg::REQ_SET_LINE: begin
            emit    = 1'b1;
            is_addr = 1'b1;
            target  = req_line_sel;
         end
         cnw_pkg::REQ_GOTO: begin
            // rows past the display produce nothing
            if (row_eff < 8'(cnw_pkg::NUM_LINES) && row_eff < 8'd4) begin
               emit    = 1'b1;
               use_col = 1'b1;
               idx     = row_eff[1:0];
            end
         end
         cnw_pkg::REQ_CLEAR: begin
            emit        = 1'b1;
            plain_byte  = cnw_pkg::CMD_CLEAR_DISPLAY;
            cur_line_in = 8'd0;
         end
         cnw_pkg::REQ_HOME: begin
            emit        = 1'b1;
            plain_byte  = cnw_pkg::CMD_RETURN_HOME;
            cur_line_in = 8'd0;
         end
         default: emit = 1'b0;
      endcase

      if (is_addr) begin
         cur_line_in = target;
         idx         = (target < 8'd4) ? target[1:0] : 2'd0;
      end

      // byte writes pay off the clear delay, then clear sets it again
      if (emit && !is_init) pend_in = 1'b0;
      if (cnw_pkg::req_code_type'(req_type) == cnw_pkg::REQ_CLEAR) pend_in = 1'b1;
   end

   assign addr_byte = 8'(cnw_pkg::CMD_SET_DDRAM + {1'b0, line_start_ff[idx]}
                         + (use_col ? req_col : 8'd0));

   assign wait_calc = cnw_pkg::WAIT_CALC_W'(cnw_pkg::E_PULSE_US + cnw_pkg::BUSY_WAIT_US)
                    + (pend_ff ? cnw_pkg::WAIT_CALC_W'(cnw_pkg::CLEAR_WAIT_US) : '0);

   assign q_push        = accept && emit;
   assign q_cmd.is_init = is_init;
   assign q_cmd.rs      = rs;
   assign q_cmd.data    = (is_addr || use_col) ? addr_byte : plain_byte;
   assign q_cmd.wait0   = cnw_pkg::sat_wait(wait_calc);

endmodule

[sv/cnw_queue.sv]
// Two-entry command queue between the front end and the strobe sequencer.
// Depends on cnw_pkg for the command and status types.
module cnw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cnw_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output cnw_pkg::cmd_type      head,
   output cnw_pkg::q_status_type status
);

   cnw_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = 2'(count_ff + 2'd1);
      else if (pop && !push) count_in = 2'(count_ff - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

[sv/cnw_back.sv]
// Strobe sequencer: expands the queue head into E-strobe events and holds
// them in the output register. Depends on cnw_pkg.
module cnw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  cnw_pkg::cmd_type             head,
   input  cnw_pkg::q_status_type        q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_reg_select,
   output logic [3:0]                   rsp_nibble,
   output logic [cnw_pkg::WAIT_W-1:0]   rsp_wait_us,
   output logic                         rsp_last
);

   logic [cnw_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       valid_ff, valid_in;
   logic                       rs_ff;
   logic [3:0]                 nib_ff;
   logic [cnw_pkg::WAIT_W-1:0] wait_ff;
   logic                       last_ff;

   logic                       advance;
   logic                       fire;
   logic                       is_last;
   cnw_pkg::strobe_type        strobe;

   assign advance = !valid_ff || !rsp_stall;
   assign fire    = advance && !q_status.empty;

   always_comb begin
      if (head.is_init) begin
         strobe  = cnw_pkg::init_strobe(step_ff);
         is_last = (step_ff == cnw_pkg::INIT_LAST_STEP);
      end else begin
         strobe.nibble  = (step_ff == '0) ? head.data[7:4] : head.data[3:0];
         strobe.wait_us = (step_ff == '0) ? head.wait0
                                          : cnw_pkg::WAIT_W'(cnw_pkg::E_PULSE_US);
         is_last = (step_ff == cnw_pkg::BYTE_LAST_STEP);
      end
      step_in  = step_ff;
      valid_in = valid_ff;
      if (advance) valid_in = !q_status.empty;
      if (fire) step_in = is_last ? '0 : cnw_pkg::STEP_W'(step_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // payload loads only with a new strobe, so a stalled output holds
   always_ff @(posedge clock) begin
      if (fire) begin
         rs_ff   <= head.rs && !head.is_init;
         nib_ff  <= strobe.nibble;
         wait_ff <= strobe.wait_us;
         last_ff <= is_last;
      end
   end

   assign pop            = fire && is_last;
   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_wait_us    = wait_ff;
   assign rsp_last       = last_ff;

endmodule

[sv/char_lcd_nibble_writer_top.sv]
// Top level of the character LCD nibble writer: front end, command queue and
// strobe sequencer. Depends on cnw_pkg, cnw_front, cnw_queue and cnw_back.

// Each request expands into E-strobe events for an HD44780-style display in
// 4-bit mode: a byte write gives two strobes, high nibble first, init gives
// eleven, an out-of-range goto or unused type gives none. The sequencer emits
// one strobe per cycle while the queue holds a command and the output is not
// stalled; a two-entry queue lets the next requests be taken while a command
// is still being expanded and lets either side stall. Each strobe carries the
// minimum wait in microseconds before it; pacing the pins is left to the
// consumer. The user must write line start addresses through the csr port only
// while the block is idle; the block itself does not enforce this.
module char_lcd_nibble_writer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_type,
   input  logic [7:0]                 req_data_byte,
   input  logic [7:0]                 req_line_sel,
   input  logic [7:0]                 req_col,
   input  logic [7:0]                 req_row,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_reg_select,
   output logic [3:0]                 rsp_nibble,
   output logic [cnw_pkg::WAIT_W-1:0] rsp_wait_us,
   output logic                       rsp_last,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [cnw_pkg::ADDR_W-1:0] csr_wdata
);

   logic                  q_push;
   logic                  q_pop;
   cnw_pkg::cmd_type      q_cmd;
   cnw_pkg::cmd_type      q_head;
   cnw_pkg::q_status_type q_status;

   assign req_stall = q_status.full;

   cnw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .req_line_sel  (req_line_sel),
      .req_col       (req_col),
      .req_row       (req_row),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_push        (q_push),
      .q_cmd         (q_cmd)
   );

   cnw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   cnw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_status       (q_status),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_last       (rsp_last)
   );

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !q_pop)
      else $error("pop from empty queue");

   // the rest of a command follows without a gap once a strobe is taken
   a_strobes_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid)
      else $error("gap inside a command's strobes");

endmodule

[tb/sv/char_lcd_nibble_writer_checker.sv]
// Strobe checker for the character LCD nibble writer: watches the request, strobe
// and csr ports, predicts every E strobe and compares it with what the block emits.
// Depends on cnw_pkg for the request codes and port widths.
module char_lcd_nibble_writer_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [2:0]                 req_type,
   input  logic [7:0]                 req_data_byte,
   input  logic [7:0]                 req_line_sel,
   input  logic [7:0]                 req_col,
   input  logic [7:0]                 req_row,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_reg_select,
   input  logic [3:0]                 rsp_nibble,
   input  logic [cnw_pkg::WAIT_W-1:0] rsp_wait_us,
   input  logic                       rsp_last,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [cnw_pkg::ADDR_W-1:0] csr_wdata,
   output int                         error_count,
   output int                         strobes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ROWS         = 4;
   localparam int unsigned T_PULSE      = 10;
   localparam int unsigned T_BUSY       = 1000;
   localparam int unsigned T_POWER_ON   = 25000;
   localparam int unsigned T_WAKE_GAP   = 2000;
   localparam int unsigned T_WAKE_SHORT = 64;
   localparam int unsigned T_SETUP_GAP  = 2500;
   localparam int unsigned T_CLEAR_OWED = 500;
   localparam int unsigned T_CEIL       = 32767;

   localparam logic [7:0] OP_DDRAM     = 8'h80;
   localparam logic [7:0] OP_FUNC_SET  = 8'h28;
   localparam logic [7:0] OP_ENTRY     = 8'h06;
   localparam logic [7:0] OP_DISP_ON   = 8'h0C;
   localparam logic [7:0] OP_HOME      = 8'h02;
   localparam logic [7:0] OP_CLEAR     = 8'h01;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [3:0] WAKE_NIB     = 4'h3;
   localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

   typedef struct packed {
      logic                       rs;
      logic [3:0]                 nib;
      logic [cnw_pkg::WAIT_W-1:0] wait_us;
      logic                       last;
   } lcd_strobe_type;

   logic [6:0]     start_addr [4];
   logic [7:0]     line_now;
   logic [9:0]     clear_owed;
   lcd_strobe_type strobes_due [$];
   lcd_strobe_type cmd_strobes [$];

   function automatic logic [cnw_pkg::WAIT_W-1:0] clip_us(input int unsigned us);
      return (us > T_CEIL) ? cnw_pkg::WAIT_W'(T_CEIL) : cnw_pkg::WAIT_W'(us);
   endfunction

   function void add_strobe(input logic rs, input logic [3:0] nib, input int unsigned us);
      lcd_strobe_type s;
      s.rs      = rs;
      s.nib     = nib;
      s.wait_us = clip_us(us);
      s.last    = 1'b0;
      cmd_strobes.push_back(s);
   endfunction

   // the busy wait and any wait owed after a clear go on the high nibble
   function void add_byte(input logic rs, input logic [7:0] b, input int unsigned gap);
      int unsigned us;
      us = T_PULSE + gap + clear_owed + T_BUSY;
      clear_owed = '0;
      add_strobe(rs, b[7:4], us);
      add_strobe(rs, b[3:0], T_PULSE);
   endfunction

   function void select_line(input logic [7:0] ln);
      logic [7:0] addr;
      addr = OP_DDRAM + {1'b0, (ln < ROWS) ? start_addr[ln[1:0]] : start_addr[0]};
      line_now = ln;
      add_byte(1'b0, addr, 0);
   endfunction

   function void expand_command(input logic [2:0] kind, input logic [7:0] d,
                                input logic [7:0] lsel, input logic [7:0] col,
                                input logic [7:0] row);
      logic [7:0] addr;
      cmd_strobes.delete();
      case (cnw_pkg::req_code_type'(kind))
         cnw_pkg::REQ_INIT: begin
            clear_owed = '0;
            add_strobe(1'b0, WAKE_NIB, T_POWER_ON);
            add_strobe(1'b0, WAKE_NIB, T_PULSE + T_WAKE_GAP);
            add_strobe(1'b0, FOUR_BIT_NIB, T_PULSE + T_WAKE_SHORT);
            add_byte(1'b0, OP_FUNC_SET, T_WAKE_GAP);
            add_byte(1'b0, OP_ENTRY, T_WAKE_GAP);
            add_byte(1'b0, OP_DISP_ON, T_SETUP_GAP);
            line_now = '0;
            add_byte(1'b0, OP_HOME, T_SETUP_GAP);
         end
         cnw_pkg::REQ_CHAR: begin
            if (d == NEWLINE_CHAR) begin
               if (line_now >= ROWS - 1) select_line(8'd0);
               else select_line(line_now + 8'd1);
            end else begin
               add_byte(1'b1, d, 0);
            end
         end
         cnw_pkg::REQ_INSTR: add_byte(1'b0, d, 0);
         cnw_pkg::REQ_SET_LINE: select_line(lsel);
         cnw_pkg::REQ_GOTO: begin
            // rows past the display are dropped without touching any state
            if (row < ROWS) begin
               addr = OP_DDRAM + {1'b0, start_addr[row[1:0]]} + col;
               add_byte(1'b0, addr, 0);
            end
         end
         cnw_pkg::REQ_CLEAR: begin
            line_now = '0;
            add_byte(1'b0, OP_CLEAR, 0);
            clear_owed = 10'(T_CLEAR_OWED);
         end
         cnw_pkg::REQ_HOME: begin
            line_now = '0;
            add_byte(1'b0, OP_HOME, 0);
         end
         default: ;
      endcase
      if (cmd_strobes.size() > 0) cmd_strobes[$].last = 1'b1;
      foreach (cmd_strobes[i]) strobes_due.push_back(cmd_strobes[i]);
   endfunction

   function void check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      lcd_strobe_type want;
      if (reset) begin
         start_addr[0] = 7'd0;
         start_addr[1] = 7'd64;
         start_addr[2] = 7'd20;
         start_addr[3] = 7'd84;
         line_now      = '0;
         clear_owed    = '0;
         error_count   = 0;
         strobes_due.delete();
      end else begin
         if (csr_we) start_addr[csr_index] = csr_wdata;
         // compare before predicting: a request taken now cannot show up on this edge
         if (rsp_valid && !rsp_stall) begin
            if (strobes_due.size() == 0) begin
               $error("strobe with no request behind it: rs %0d nibble %0h wait %0d last %0d",
                      rsp_reg_select, rsp_nibble, rsp_wait_us, rsp_last);
               error_count++;
            end else begin
               want = strobes_due.pop_front();
               check_field("reg_select", 32'(want.rs), 32'(rsp_reg_select));
               check_field("nibble", 32'(want.nib), 32'(rsp_nibble));
               check_field("wait_us", 32'(want.wait_us), 32'(rsp_wait_us));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            expand_command(req_type, req_data_byte, req_line_sel, req_col, req_row);
      end
      strobes_owed = strobes_due.size();
   end

endmodule

[tb/sv/char_lcd_nibble_writer_top_tb.sv]
// Top of the nibble writer testbench: clock, reset, request and csr stimulus,
// strobe back-pressure and the verdict. Depends on cnw_pkg, the block and
// char_lcd_nibble_writer_checker.
module char_lcd_nibble_writer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_PER_SET = 73;
   localparam int NUM_SETS       = 6;

   localparam logic [2:0] REQ_UNUSED   = 3'd7;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [1:0] LINE0_IDX    = 2'd0;
   localparam logic [1:0] LINE1_IDX    = 2'd1;
   localparam logic [1:0] LINE2_IDX    = 2'd2;
   localparam logic [1:0] LINE3_IDX    = 2'd3;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [2:0]                 req_type      = '0;
   logic [7:0]                 req_data_byte = '0;
   logic [7:0]                 req_line_sel  = '0;
   logic [7:0]                 req_col       = '0;
   logic [7:0]                 req_row       = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic                       rsp_reg_select;
   logic [3:0]                 rsp_nibble;
   logic [cnw_pkg::WAIT_W-1:0] rsp_wait_us;
   logic                       rsp_last;
   logic                       csr_we        = 1'b0;
   logic [1:0]                 csr_index     = '0;
   logic [cnw_pkg::ADDR_W-1:0] csr_wdata     = '0;

   int error_count;
   int strobes_owed;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   bit hold_go       = 1'b0;

   char_lcd_nibble_writer_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_line_sel   (req_line_sel),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   char_lcd_nibble_writer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_line_sel   (req_line_sel),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .strobes_owed   (strobes_owed)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // strobe side back-pressure; one long hold-off when asked for
   always @(negedge clock) begin
      int hold_left;
      bit hold_used;
      if (hold_go && !hold_used) begin
         hold_used = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < take_idle_pct);
      end
   end

   // enter and leave on a falling edge
   task automatic send_cmd(input logic [2:0] kind, input logic [7:0] d, input logic [7:0] lsel,
                           input logic [7:0] col, input logic [7:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_data_byte <= d;
      req_line_sel  <= lsel;
      req_col       <= col;
      req_row       <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // shorthand for directed requests: every field is passed to send_cmd as given
   task automatic send_sparse(input logic [2:0] kind, input logic [7:0] d,
                              input logic [7:0] lsel, input logic [7:0] col,
                              input logic [7:0] row);
      send_cmd(kind, d, lsel, col, row);
   endtask

   task automatic send_random_cmd();
      int pick;
      logic [2:0] kind;
      logic [7:0] d;
      logic [7:0] l;
      logic [7:0] c;
      logic [7:0] r;
      d    = 8'($urandom);
      l    = 8'($urandom);
      c    = 8'($urandom);
      r    = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 33) begin
         kind = cnw_pkg::REQ_CHAR;
      end else if (pick < 43) begin
         kind = cnw_pkg::REQ_CHAR;
         d    = NEWLINE_CHAR;
      end else if (pick < 53) begin
         kind = cnw_pkg::REQ_INSTR;
      end else if (pick < 63) begin
         kind = cnw_pkg::REQ_SET_LINE;
         if ($urandom_range(3) != 0) l = 8'($urandom_range(3));
      end else if (pick < 80) begin
         kind = cnw_pkg::REQ_GOTO;
         if ($urandom_range(4) != 0) r = 8'($urandom_range(3));
      end else if (pick < 87) begin
         kind = cnw_pkg::REQ_CLEAR;
      end else if (pick < 93) begin
         kind = cnw_pkg::REQ_HOME;
      end else if (pick < 97) begin
         kind = cnw_pkg::REQ_INIT;
      end else begin
         kind = REQ_UNUSED;
      end
      send_cmd(kind, d, l, c, r);
   endtask

   // drop valid, wait for every strobe, then let a dropped request finish
   task automatic drain();
      req_valid <= 1'b0;
      wait (strobes_owed == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_line_starts(input logic [6:0] a0, input logic [6:0] a1,
                                    input logic [6:0] a2, input logic [6:0] a3);
      logic [6:0] vals [4];
      logic [1:0] idx [4];
      vals = '{a0, a1, a2, a3};
      idx  = '{LINE0_IDX, LINE1_IDX, LINE2_IDX, LINE3_IDX};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 22;
      take_idle_pct = 63;

      // directed part on the reset line starts
      send_sparse(cnw_pkg::REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_CHAR, 8'h00, 8'h00, 8'h00, 8'h00);
      send_sparse(cnw_pkg::REQ_CHAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (4) send_sparse(cnw_pkg::REQ_CHAR, NEWLINE_CHAR, 8'($urandom), 8'($urandom),
                             8'($urandom));
      send_sparse(cnw_pkg::REQ_INSTR, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_sparse(cnw_pkg::REQ_INSTR, 8'hFF, 8'h00, 8'hFF, 8'h00);
      send_sparse(cnw_pkg::REQ_SET_LINE, 8'($urandom), 8'd3, 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_SET_LINE, 8'($urandom), 8'd4, 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_SET_LINE, 8'($urandom), 8'd255, 8'($urandom), 8'($urandom));
      // newline from a line past the display goes back to line 0
      send_sparse(cnw_pkg::REQ_CHAR, NEWLINE_CHAR, 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_GOTO, 8'($urandom), 8'($urandom), 8'd0, 8'd0);
      send_sparse(cnw_pkg::REQ_GOTO, 8'($urandom), 8'($urandom), 8'd255, 8'd3);
      send_sparse(cnw_pkg::REQ_GOTO, 8'($urandom), 8'($urandom), 8'($urandom), 8'd4);
      send_sparse(cnw_pkg::REQ_GOTO, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
      send_sparse(cnw_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      // the owed clear wait survives an ignored goto and lands on the next byte
      send_sparse(cnw_pkg::REQ_GOTO, 8'($urandom), 8'($urandom), 8'($urandom), 8'd4);
      send_sparse(cnw_pkg::REQ_CHAR, 8'h41, 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_HOME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_sparse(cnw_pkg::REQ_HOME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      drain();

      for (int set = 0; set < NUM_SETS; set++) begin
         case (set)
            0: write_line_starts(7'd0, 7'd0, 7'd0, 7'd0);
            1: write_line_starts(7'd127, 7'd127, 7'd127, 7'd127);
            3: write_line_starts(7'd127, 7'd0, 7'd127, 7'd0);
            5: write_line_starts(7'd0, 7'd64, 7'd20, 7'd84);
            default: write_line_starts(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
         endcase
         if (set < 2) begin
            send_idle_pct = 22;
            take_idle_pct = 63;
         end else if (set < 4) begin
            send_idle_pct = 63;
            take_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            // hold the strobe side off while requests keep coming
            if (set == 4 && n == 10) hold_go = 1'b1;
            send_random_cmd();
         end
         drain();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
